// ===== rtl/elevator_order_table_defines.svh =====
// ----------------------------------------------------------------------------
// Elevator order table assertion macros
// Concurrent assertion shorthands on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ELEVATOR_ORDER_TABLE_DEFINES_SVH
`define ELEVATOR_ORDER_TABLE_DEFINES_SVH

// same-cycle implication
`define EOT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EOT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/eot_pkg.sv =====
// ----------------------------------------------------------------------------
// Elevator order table package
// Shared types and constants for the floor cells and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package eot_pkg;

  localparam int NUM_FLOORS_DEF = 4;
  localparam int BTN_W          = 4;
  localparam int FLOOR_W        = 2;
  localparam int IN_TDATA_W     = 24;
  localparam int OUT_TDATA_W    = 16;

  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  // pending orders of one floor
  typedef struct packed {
    logic up;
    logic down;
    logic cab;
  } ord_t;

  // per-transfer control shared by all cells
  typedef struct packed {
    logic take;
    logic clr_all;
    dir_t dir;
  } eot_ctrl_t;

  // decision of the cell at the current floor
  typedef struct packed {
    logic stop;
    logic keep;
  } vote_t;

endpackage

`default_nettype wire

// ===== rtl/eot_cell.sv =====
// ----------------------------------------------------------------------------
// Elevator order table floor cell
// Holds one floor's pending orders, extends the below/above order chains
// and forms the stop/continue decision when the car is at this floor.
// ----------------------------------------------------------------------------
`default_nettype none

module eot_cell #(
  parameter int FLOOR      = 0,
  parameter int NUM_FLOORS = eot_pkg::NUM_FLOORS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  eot_pkg::ord_t         btn,
  input  eot_pkg::eot_ctrl_t    ctrl,
  input  wire logic             cur_hit,
  input  wire logic             clr_hit,
  input  wire logic             below_in,
  input  wire logic             above_in,
  output logic                  below_out,
  output logic                  above_out,
  output eot_pkg::vote_t        vote,
  output eot_pkg::ord_t         post
);
  import eot_pkg::*;

  localparam bit AT_BOTTOM = (FLOOR == 0);
  localparam bit AT_TOP    = (FLOOR == NUM_FLOORS - 1);

  ord_t p_r, p_nxt, p_add;
  logic here;

  always_comb begin
    p_add = ord_t'(p_r | btn);
    here  = |p_add;
    post  = (clr_hit || ctrl.clr_all) ? ord_t'('0) : p_add;
    p_nxt = ctrl.take ? post : p_r;
  end

  assign below_out = below_in | here;
  assign above_out = above_in | here;

  always_comb begin
    vote = '0;
    if (cur_hit) begin
      case (ctrl.dir)
        DIR_DOWN: begin
          vote.stop = p_add.down | p_add.cab | (here & ~below_in) | AT_BOTTOM;
          vote.keep = below_in;
        end
        DIR_UP: begin
          vote.stop = p_add.up | p_add.cab | (here & ~above_in) | AT_TOP;
          vote.keep = above_in;
        end
        default: begin
          vote.stop = 1'b1;
          vote.keep = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= '0;
    end else begin
      p_r <= p_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/elevator_order_table.sv =====
// Elevator order table: pending-order store of a directional collective
// elevator controller, one cell per floor in a chain.
// Input channel in_*: one transfer per controller tick carrying the pressed
// cab, hall-down and hall-up buttons, the clear requests, the travel
// direction and the current floor. Buttons are added to the table, the
// stop/continue answer is formed from the updated table, then the clears
// apply.
// Output channel out_*: one transfer per input transfer with stop_here,
// keep_going and the lamp state after the clears.
// out_tvalid rises in the cycle after the input transfer. One transfer per
// cycle is taken while the receiver does not stall; the cycle is set by the
// order chains that ripple through the floor cells, one cell per floor.
// Reset (rst_n low, synchronous) empties the table and clears out_tvalid.
// While the receiver stalls, the held result stays and in_tready drops, so
// a new transfer is taken only as the held one leaves.
// ----------------------------------------------------------------------------
// Elevator order table top level
// Stream wrapper, floor cell chain and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "elevator_order_table_defines.svh"

module elevator_order_table #(
  parameter int NUM_FLOORS = eot_pkg::NUM_FLOORS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // cab_buttons, hall_down_buttons, hall_up_buttons, clear_floor_enable,
  // clear_floor_number, clear_everything, direction, current_floor, pad
  input  wire logic [eot_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // stop_here, keep_going, cab_lamps, down_lamps, up_lamps, pad
  output logic [eot_pkg::OUT_TDATA_W-1:0]         out_tdata
);
  import eot_pkg::*;

  logic [BTN_W-1:0]   cab_buttons, hall_down_buttons, hall_up_buttons;
  logic               clear_floor_enable, clear_everything;
  logic [FLOOR_W-1:0] clear_floor_number, current_floor;
  dir_t               direction;

  assign cab_buttons        = in_tdata[3:0];
  assign hall_down_buttons  = in_tdata[7:4];
  assign hall_up_buttons    = in_tdata[11:8];
  assign clear_floor_enable = in_tdata[12];
  assign clear_floor_number = in_tdata[14:13];
  assign clear_everything   = in_tdata[15];
  assign direction          = dir_t'(in_tdata[17:16]);
  assign current_floor      = in_tdata[19:18];

  logic      take;
  eot_ctrl_t ctrl;
  logic      out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign take      = in_tvalid && in_tready;

  assign ctrl.take    = take;
  assign ctrl.clr_all = clear_everything;
  assign ctrl.dir     = direction;

  logic  below [NUM_FLOORS+1];
  logic  above [NUM_FLOORS+1];
  vote_t vote  [NUM_FLOORS];
  ord_t  post  [NUM_FLOORS];

  assign below[0]          = 1'b0;
  assign above[NUM_FLOORS] = 1'b0;

  for (genvar f = 0; f < NUM_FLOORS; f++) begin : g_cell
    ord_t btn;
    logic cur_hit, clr_hit;

    if (f < BTN_W) begin : g_btn
      assign btn.cab  = cab_buttons[f];
      assign btn.down = hall_down_buttons[f];
      assign btn.up   = hall_up_buttons[f];
    end else begin : g_nobtn
      assign btn = '0;
    end

    if (f == NUM_FLOORS - 1) begin : g_top
      assign cur_hit = (int'(current_floor) >= f);
    end else begin : g_mid
      assign cur_hit = (int'(current_floor) == f);
    end
    assign clr_hit = clear_floor_enable && (int'(clear_floor_number) == f);

    eot_cell #(
      .FLOOR      (f),
      .NUM_FLOORS (NUM_FLOORS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .btn       (btn),
      .ctrl      (ctrl),
      .cur_hit   (cur_hit),
      .clr_hit   (clr_hit),
      .below_in  (below[f]),
      .above_in  (above[f+1]),
      .below_out (below[f+1]),
      .above_out (above[f]),
      .vote      (vote[f]),
      .post      (post[f])
    );
  end

  logic [BTN_W-1:0] cab_lamps, down_lamps, up_lamps;

  for (genvar l = 0; l < BTN_W; l++) begin : g_lamp
    if (l < NUM_FLOORS) begin : g_on
      assign cab_lamps[l]  = post[l].cab;
      assign down_lamps[l] = post[l].down;
      assign up_lamps[l]   = post[l].up;
    end else begin : g_off
      assign cab_lamps[l]  = 1'b0;
      assign down_lamps[l] = 1'b0;
      assign up_lamps[l]   = 1'b0;
    end
  end

  logic stop_here, keep_going;

  always_comb begin
    stop_here  = 1'b0;
    keep_going = 1'b0;
    for (int f = 0; f < NUM_FLOORS; f++) begin
      stop_here  = stop_here  | vote[f].stop;
      keep_going = keep_going | vote[f].keep;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {2'b00, up_lamps, down_lamps, cab_lamps, keep_going, stop_here};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `EOT_ASSERT_NEXT(a_take_fills, take, out_valid_r, "accepted transfer gave no result")
  `EOT_ASSERT_NOW(a_stall_blocks, out_valid_r && !out_tready, !in_tready, "input taken while held")
  `EOT_ASSERT_NEXT(a_clear_all, take && clear_everything, out_data_r[13:2] == '0, "table not cleared")
  `EOT_ASSERT_NEXT(a_idle_stops, take && direction == DIR_IDLE, out_data_r[1:0] == 2'b01, "idle must stop")

endmodule

`default_nettype wire

// ===== tb/elevator_order_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Elevator order table testbench
// Streams button/clear/direction ticks into the order table and checks every
// answer and lamp state against a behavioural model of the pending-order
// table. Sender bursts, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------

module elevator_order_table_tb;

  import eot_pkg::*;

  localparam int          FLOOR_CNT  = NUM_FLOORS_DEF;
  localparam int          N_RANDOM   = 1430;
  localparam int          LIMIT      = 200000;
  localparam int          HOLD_CYCLES = 120;
  localparam logic [1:0]  DIR_UNUSED = 2'd3;

  // one input transfer, lowest field last
  typedef struct packed {
    logic [1:0] cf;
    dir_t       dir;
    logic       clr_all;
    logic [1:0] clr_num;
    logic       clr_en;
    logic [3:0] up;
    logic [3:0] down;
    logic [3:0] cab;
  } tick_t;

  // one result transfer, lowest field last
  typedef struct packed {
    logic [3:0] up;
    logic [3:0] down;
    logic [3:0] cab;
    logic       keep;
    logic       stop;
  } answer_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  tick_t   tick_queue[$];
  answer_t answer_queue[$];
  logic [3:0] cab_tbl, down_tbl, up_tbl;

  logic     in_fire = 1'b0;
  logic     hold_off = 1'b0;
  int       n_ticks = 0;
  int       ticks_taken = 0;
  int       answers_seen = 0;
  int       stops_seen = 0;
  int       keeps_seen = 0;
  int       input_stalls = 0;
  int       mismatches = 0;
  int       cycles = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       rx_left = 0;
  rx_mode_t rx_mode = RX_FREE;
  logic     rx_ready;
  tick_t    seen_tick;
  answer_t  got, want;

  elevator_order_table u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // adds buttons, answers for the current floor, then applies clears
  function automatic answer_t serve_tick(tick_t t);
    logic [3:0] any;
    logic [3:0] below;
    logic [3:0] above;
    logic       here;
    int         cf;
    answer_t    a;
    cab_tbl  |= t.cab;
    down_tbl |= t.down;
    up_tbl   |= t.up;
    cf = (t.cf > FLOOR_CNT - 1) ? FLOOR_CNT - 1 : t.cf;
    any = cab_tbl | down_tbl | up_tbl;
    here = any[cf];
    below = '0;
    above = '0;
    for (int f = 0; f < 4; f++) begin
      if (f < cf) below[f] = any[f];
      if (f > cf) above[f] = any[f];
    end
    a = '0;
    a.stop = 1'b1;
    if (t.dir == DIR_DOWN) begin
      a.stop = down_tbl[cf] | cab_tbl[cf] | (here && below == '0) | (cf == 0);
      a.keep = |below;
    end else if (t.dir == DIR_UP) begin
      a.stop = up_tbl[cf] | cab_tbl[cf] | (here && above == '0) | (cf == FLOOR_CNT - 1);
      a.keep = |above;
    end
    if (t.clr_en && t.clr_num < FLOOR_CNT) begin
      cab_tbl[t.clr_num]  = 1'b0;
      down_tbl[t.clr_num] = 1'b0;
      up_tbl[t.clr_num]   = 1'b0;
    end
    if (t.clr_all) begin
      cab_tbl  = '0;
      down_tbl = '0;
      up_tbl   = '0;
    end
    a.cab  = cab_tbl;
    a.down = down_tbl;
    a.up   = up_tbl;
    return a;
  endfunction

  task automatic add_tick(logic [3:0] cab, logic [3:0] down, logic [3:0] up, logic clr_en,
                          logic [1:0] clr_num, logic clr_all, logic [1:0] dir,
                          logic [1:0] cf);
    tick_t t;
    t.cab     = cab;
    t.down    = down;
    t.up      = up;
    t.clr_en  = clr_en;
    t.clr_num = clr_num;
    t.clr_all = clr_all;
    t.dir     = dir_t'(dir);
    t.cf      = cf;
    tick_queue.push_back(t);
    n_ticks++;
  endtask

  function automatic logic [3:0] few_presses();
    logic [3:0] b;
    for (int f = 0; f < 4; f++) b[f] = ($urandom_range(0, 7) == 0);
    return b;
  endfunction

  task automatic report(string field, int exp_val, int act_val);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s expected %0h got %0h", $realtime, field, exp_val, act_val);
  endtask

  // input driver: bursts of transfers separated by random gaps
  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (tick_queue.size() != 0) begin
        in_tdata  <= {{(IN_TDATA_W - $bits(tick_t)){1'b0}}, tick_queue.pop_front()};
        in_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver: stall pattern switches among free, light, heavy and toggle modes
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 40);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_FREE:  rx_ready = 1'b1;
      RX_LIGHT: rx_ready = ($urandom_range(0, 3) != 0);
      RX_HEAVY: rx_ready = ($urandom_range(0, 3) == 0);
      default:  rx_ready = rx_left[0];
    endcase
    out_tready <= rx_ready && !hold_off;
  end

  // long hold-off so the block fills and drops in_tready
  initial begin
    wait (ticks_taken >= 300);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // monitor: predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      if (in_tvalid && !in_tready) input_stalls++;
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(answer_t)-1:0];
        answers_seen++;
        if (got.stop) stops_seen++;
        if (got.keep) keeps_seen++;
        if (answer_queue.size() == 0) begin
          report("unexpected result", 0, int'(got));
        end else begin
          want = answer_queue.pop_front();
          if (got.stop !== want.stop)
            report("stop_here", int'(want.stop), int'(got.stop));
          if (got.keep !== want.keep)
            report("keep_going", int'(want.keep), int'(got.keep));
          if (got.cab !== want.cab) report("cab_lamps", int'(want.cab), int'(got.cab));
          if (got.down !== want.down)
            report("down_lamps", int'(want.down), int'(got.down));
          if (got.up !== want.up) report("up_lamps", int'(want.up), int'(got.up));
        end
      end
      in_fire <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        seen_tick = in_tdata[$bits(tick_t)-1:0];
        answer_queue.push_back(serve_tick(seen_tick));
        ticks_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    tick_t      t;
    logic [31:0] noise;
    logic [1:0]  d;
    cab_tbl  = '0;
    down_tbl = '0;
    up_tbl   = '0;

    // directed ticks
    add_tick(4'h0, 4'h0, 4'h0, 1'b0, 2'd0, 1'b0, DIR_IDLE, 2'd0);
    add_tick(4'hF, 4'hF, 4'hF, 1'b0, 2'd0, 1'b0, DIR_IDLE, 2'd3);
    add_tick(4'h0, 4'h0, 4'h0, 1'b0, 2'd0, 1'b0, DIR_DOWN, 2'd0);
    add_tick(4'h0, 4'h0, 4'h0, 1'b0, 2'd0, 1'b0, DIR_UP, 2'd3);
    add_tick(4'h0, 4'h0, 4'h0, 1'b0, 2'd0, 1'b0, DIR_DOWN, 2'd2);
    add_tick(4'h0, 4'h0, 4'h0, 1'b0, 2'd0, 1'b0, DIR_UP, 2'd1);
    add_tick(4'h0, 4'h0, 4'h0, 1'b0, 2'd0, 1'b0, DIR_UNUSED, 2'd1);
    for (int f = 0; f < 4; f++)
      add_tick(4'h0, 4'h0, 4'h0, 1'b1, 2'(f), 1'b0, DIR_DOWN, 2'(f));
    add_tick(4'hF, 4'hF, 4'hF, 1'b0, 2'd0, 1'b1, DIR_UP, 2'd0);
    add_tick(4'b0010, 4'h0, 4'h0, 1'b0, 2'd0, 1'b0, DIR_DOWN, 2'd3);
    add_tick(4'h0, 4'h0, 4'h0, 1'b0, 2'd0, 1'b0, DIR_DOWN, 2'd2);
    add_tick(4'h0, 4'h0, 4'h0, 1'b1, 2'd1, 1'b0, DIR_DOWN, 2'd1);
    add_tick(4'h0, 4'h0, 4'b0100, 1'b0, 2'd0, 1'b0, DIR_DOWN, 2'd2);
    add_tick(4'h0, 4'h0, 4'h0, 1'b0, 2'd0, 1'b0, DIR_UP, 2'd2);
    add_tick(4'h0, 4'b0001, 4'h0, 1'b0, 2'd0, 1'b0, DIR_UP, 2'd2);
    add_tick(4'h0, 4'b0010, 4'h0, 1'b0, 2'd0, 1'b0, DIR_UP, 2'd1);
    add_tick(4'h0, 4'h0, 4'h0, 1'b1, 2'd3, 1'b1, DIR_IDLE, 2'd0);
    add_tick(4'b1000, 4'h0, 4'h0, 1'b0, 2'd0, 1'b0, DIR_UP, 2'd0);
    add_tick(4'h0, 4'h0, 4'h0, 1'b1, 2'd3, 1'b0, DIR_UP, 2'd3);

    // random ticks: mostly sparse presses with serving clears, some noise
    repeat (N_RANDOM) begin
      if ($urandom_range(0, 4) == 0) begin
        noise = $urandom;
        t = noise[$bits(tick_t)-1:0];
      end else begin
        t.cab  = few_presses();
        t.down = few_presses();
        t.up   = few_presses();
        t.cf   = 2'($urandom_range(0, 3));
        d = ($urandom_range(0, 15) == 0) ? DIR_UNUSED : 2'($urandom_range(0, 2));
        t.dir     = dir_t'(d);
        t.clr_en  = ($urandom_range(0, 2) != 0);
        t.clr_num = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3)) : t.cf;
        t.clr_all = ($urandom_range(0, 39) == 0);
      end
      tick_queue.push_back(t);
      n_ticks++;
    end

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    while (ticks_taken != n_ticks || answer_queue.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("%0d ticks sent, %0d answers checked (%0d stop, %0d keep going)",
             n_ticks, answers_seen, stops_seen, keeps_seen);
    $display("%0d cycles with the input held off by back-pressure", input_stalls);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/eot_pkg.sv
rtl/eot_cell.sv
rtl/elevator_order_table.sv
tb/elevator_order_table_tb.sv
